/* rtl/core/dbtt_pkg.sv */
// ----------------------------------------------------------------------------
// dbtt_pkg
// Shared types, codes and constants of the decoded block tag table.
// ----------------------------------------------------------------------------
package dbtt_pkg;

    localparam int TABLE_BITS        = 12;
    localparam int TSIZE             = 1 << TABLE_BITS;
    localparam int FULL_SLOTS        = TSIZE * 3 / 4;
    localparam int INSN_POOL         = 16384;
    localparam int OPERAND_POOL      = 49152;
    localparam int BYTE_POOL         = 81920;
    localparam int MAX_BLOCK_INSNS   = 64;
    localparam int MAX_INSN_OPERANDS = 10;
    localparam int MAX_INSN_BYTES    = 15;

    localparam logic [63:0] GOLDEN = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [63:0] TOMB   = '1;
    localparam int HASH_TERMS      = 6;

    typedef logic [TABLE_BITS-1:0] slot_t;

    typedef enum logic [2:0] {
        CMD_LOOKUP = 3'd0,
        CMD_INSERT = 3'd1,
        CMD_INVAL  = 3'd2,
        CMD_FLUSH  = 3'd3,
        CMD_DROP   = 3'd4
    } cmd_t;

    typedef struct packed {
        logic [63:0] addr;
        logic [7:0]  mode;
        logic [9:0]  length;
        logic [13:0] first_insn;
        logic [6:0]  insn_count;
        logic [16:0] byte_offset;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [1:0] {A_SWEEP, A_PROBE, A_DROP} addr_sel_t;
    typedef enum logic [1:0] {WR_NONE, WR_ZERO, WR_TOMB, WR_ENTRY} wr_sel_t;
    typedef enum logic [2:0] {RES_NONE, RES_ZERO, RES_HIT, RES_INS, RES_FLUSH} res_sel_t;

    typedef struct packed {
        logic      load_req;
        logic      hash_clear;
        logic      hash_step;
        logic      probe_init;
        logic      probe_next;
        logic      sweep_clr;
        logic      sweep_inc;
        logic      clr_counters;
        logic      set_flushed;
        logic      commit_insert;
        logic      out_set;
        addr_sel_t addr_sel;
        wr_sel_t   wr_sel;
        res_sel_t  res_sel;
    } ctrl_t;

    typedef struct packed {
        logic [2:0] cmd;
        logic       reserved_addr;
        logic       hash_done;
        logic       need_flush;
        logic       sweep_last;
        logic       probe_last;
        logic       entry_empty;
        logic       entry_match;
        logic       entry_claim;
        logic       inval_hit;
        logic       out_free;
    } stat_t;

endpackage

/* rtl/core/decoded_block_tag_table.sv */
// ----------------------------------------------------------------------------
// decoded_block_tag_table
// Open-addressed tag table of decoded code blocks with linear probing.
// ----------------------------------------------------------------------------
// One request is handled at a time; the next one is taken while the previous
// result still waits in the output register. After reset the table is swept
// clear, one slot a cycle, before the first request is taken. A lookup or
// insert goes through dispatch, hashing (six 16x32 partial products through
// one multiplier) and a read and check of each slot probed, then hands off the
// result. An insert that has to flush first sweeps the table clear. Invalidate
// reads and checks every slot; flush sweeps the table clear and drop reads and
// checks one slot. The single RAM port carries one slot a cycle.
module decoded_block_tag_table (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  command,
    input  logic [63:0] address,
    input  logic [63:0] limit_address,
    input  logic [7:0]  cpu_mode,
    input  logic [9:0]  block_length,
    input  logic [6:0]  insn_count,
    input  logic [9:0]  operand_total,
    input  logic [11:0] slot_index,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        hit,
    output logic [11:0] slot,
    output logic [13:0] first_insn,
    output logic [15:0] first_operand,
    output logic [16:0] byte_offset,
    output logic [6:0]  block_insns,
    output logic [9:0]  block_bytes,
    output logic        flushed
);
    import dbtt_pkg::*;

    ctrl_t ctrl;
    stat_t stat;

    dbtt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    dbtt_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .command       (command),
        .address       (address),
        .limit_address (limit_address),
        .cpu_mode      (cpu_mode),
        .block_length  (block_length),
        .insn_count    (insn_count),
        .operand_total (operand_total),
        .slot_index    (slot_index),
        .ctrl          (ctrl),
        .stat          (stat),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .hit           (hit),
        .slot          (slot),
        .first_insn    (first_insn),
        .first_operand (first_operand),
        .byte_offset   (byte_offset),
        .block_insns   (block_insns),
        .block_bytes   (block_bytes),
        .flushed       (flushed)
    );

endmodule

/* rtl/core/dbtt_ram.sv */
// ----------------------------------------------------------------------------
// dbtt_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module dbtt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic                     we,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

/* rtl/core/dbtt_ctrl.sv */
// ----------------------------------------------------------------------------
// dbtt_ctrl
// Sequencer of the tag table: hash, probe, sweep and result hand-off.
// ----------------------------------------------------------------------------
module dbtt_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  dbtt_pkg::stat_t stat,
    output dbtt_pkg::ctrl_t ctrl
);
    import dbtt_pkg::*;

    typedef enum logic [11:0] {
        S_CLEAR    = 12'b0000_0000_0001,
        S_IDLE     = 12'b0000_0000_0010,
        S_DISP     = 12'b0000_0000_0100,
        S_HASH     = 12'b0000_0000_1000,
        S_HOME     = 12'b0000_0001_0000,
        S_PRB_RD   = 12'b0000_0010_0000,
        S_PRB_CHK  = 12'b0000_0100_0000,
        S_INV_RD   = 12'b0000_1000_0000,
        S_INV_CHK  = 12'b0001_0000_0000,
        S_DROP_RD  = 12'b0010_0000_0000,
        S_DROP_CHK = 12'b0100_0000_0000,
        S_DONE     = 12'b1000_0000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   ret_reg, ret_next;

    assign in_stall = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            ret_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        ctrl       = '0;
        ctrl.addr_sel = A_SWEEP;
        ctrl.wr_sel   = WR_NONE;
        ctrl.res_sel  = RES_NONE;
        case (state_reg)
            S_CLEAR:
            begin
                ctrl.wr_sel    = WR_ZERO;
                ctrl.sweep_inc = 1'b1;
                if (stat.sweep_last)
                begin
                    ret_next = 1'b0;
                    if (!ret_reg)
                        state_next = S_IDLE;
                    else if (stat.cmd == CMD_INSERT)
                        state_next = S_HOME;
                    else
                    begin
                        ctrl.res_sel = RES_FLUSH;
                        state_next   = S_DONE;
                    end
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctrl.load_req = 1'b1;
                    state_next    = S_DISP;
                end
            end
            S_DISP:
            begin
                case (stat.cmd)
                    CMD_LOOKUP, CMD_INSERT:
                    begin
                        if (stat.reserved_addr)
                        begin
                            ctrl.res_sel = RES_ZERO;
                            state_next   = S_DONE;
                        end
                        else
                        begin
                            ctrl.hash_clear = 1'b1;
                            state_next      = S_HASH;
                        end
                    end
                    CMD_INVAL:
                    begin
                        ctrl.sweep_clr = 1'b1;
                        state_next     = S_INV_RD;
                    end
                    CMD_FLUSH:
                    begin
                        ctrl.sweep_clr    = 1'b1;
                        ctrl.clr_counters = 1'b1;
                        ret_next          = 1'b1;
                        state_next        = S_CLEAR;
                    end
                    CMD_DROP:
                        state_next = S_DROP_RD;
                    default:
                    begin
                        ctrl.res_sel = RES_ZERO;
                        state_next   = S_DONE;
                    end
                endcase
            end
            S_HASH:
            begin
                ctrl.hash_step = 1'b1;
                if (stat.hash_done)
                    state_next = S_HOME;
            end
            S_HOME:
            begin
                if (stat.cmd == CMD_INSERT && stat.need_flush)
                begin
                    ctrl.sweep_clr    = 1'b1;
                    ctrl.clr_counters = 1'b1;
                    ctrl.set_flushed  = 1'b1;
                    ret_next          = 1'b1;
                    state_next        = S_CLEAR;
                end
                else
                begin
                    ctrl.probe_init = 1'b1;
                    state_next      = S_PRB_RD;
                end
            end
            S_PRB_RD:
            begin
                ctrl.addr_sel = A_PROBE;
                state_next    = S_PRB_CHK;
            end
            S_PRB_CHK:
            begin
                ctrl.addr_sel = A_PROBE;
                if (stat.cmd == CMD_INSERT)
                begin
                    if (stat.entry_claim)
                    begin
                        ctrl.wr_sel        = WR_ENTRY;
                        ctrl.commit_insert = 1'b1;
                        ctrl.res_sel       = RES_INS;
                        state_next         = S_DONE;
                    end
                    else
                    begin
                        ctrl.probe_next = 1'b1;
                        state_next      = S_PRB_RD;
                    end
                end
                else if (stat.entry_empty)
                begin
                    ctrl.res_sel = RES_ZERO;
                    state_next   = S_DONE;
                end
                else if (stat.entry_match)
                begin
                    ctrl.res_sel = RES_HIT;
                    state_next   = S_DONE;
                end
                else if (stat.probe_last)
                begin
                    ctrl.res_sel = RES_ZERO;
                    state_next   = S_DONE;
                end
                else
                begin
                    ctrl.probe_next = 1'b1;
                    state_next      = S_PRB_RD;
                end
            end
            S_INV_RD:
                state_next = S_INV_CHK;
            S_INV_CHK:
            begin
                if (stat.inval_hit)
                    ctrl.wr_sel = WR_TOMB;
                if (stat.sweep_last)
                begin
                    ctrl.res_sel = RES_ZERO;
                    state_next   = S_DONE;
                end
                else
                begin
                    ctrl.sweep_inc = 1'b1;
                    state_next     = S_INV_RD;
                end
            end
            S_DROP_RD:
            begin
                ctrl.addr_sel = A_DROP;
                state_next    = S_DROP_CHK;
            end
            S_DROP_CHK:
            begin
                ctrl.addr_sel = A_DROP;
                if (!stat.entry_empty)
                    ctrl.wr_sel = WR_TOMB;
                ctrl.res_sel = RES_ZERO;
                state_next   = S_DONE;
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    ctrl.out_set = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_CLEAR;
        endcase
    end

endmodule

/* rtl/core/dbtt_dp.sv */
// ----------------------------------------------------------------------------
// dbtt_dp
// Datapath: request registers, hash, slot RAM, pool counters and result.
// ----------------------------------------------------------------------------
module dbtt_dp (
    input  logic            clk,
    input  logic            rst_n,
    input  logic [2:0]      command,
    input  logic [63:0]     address,
    input  logic [63:0]     limit_address,
    input  logic [7:0]      cpu_mode,
    input  logic [9:0]      block_length,
    input  logic [6:0]      insn_count,
    input  logic [9:0]      operand_total,
    input  logic [11:0]     slot_index,
    input  dbtt_pkg::ctrl_t ctrl,
    output dbtt_pkg::stat_t stat,
    output logic            out_valid,
    input  logic            out_stall,
    output logic            hit,
    output logic [11:0]     slot,
    output logic [13:0]     first_insn,
    output logic [15:0]     first_operand,
    output logic [16:0]     byte_offset,
    output logic [6:0]      block_insns,
    output logic [9:0]      block_bytes,
    output logic            flushed
);
    import dbtt_pkg::*;

    // request
    logic [2:0]  cmd_reg;
    logic [63:0] addr_reg, lim_reg;
    logic [7:0]  mode_reg;
    slot_t       drop_reg;
    logic [6:0]  ni_reg;
    logic [9:0]  no_reg, nb_reg;
    logic [6:0]  ni_sat;
    logic [10:0] cap_o, cap_b;
    logic [9:0]  no_sat, nb_sat;

    assign ni_sat = (insn_count > 7'(MAX_BLOCK_INSNS)) ? 7'(MAX_BLOCK_INSNS) : insn_count;
    assign cap_o  = 11'(ni_sat) * 11'(MAX_INSN_OPERANDS);
    assign cap_b  = 11'(ni_sat) * 11'(MAX_INSN_BYTES);
    assign no_sat = ({1'b0, operand_total} > cap_o) ? cap_o[9:0] : operand_total;
    assign nb_sat = ({1'b0, block_length} > cap_b) ? cap_b[9:0] : block_length;

    always_ff @(posedge clk)
    begin
        if (ctrl.load_req)
        begin
            cmd_reg  <= command;
            addr_reg <= address;
            lim_reg  <= limit_address;
            mode_reg <= cpu_mode;
            drop_reg <= slot_t'(slot_index);
            ni_reg   <= ni_sat;
            no_reg   <= no_sat;
            nb_reg   <= nb_sat;
        end
    end

    // hash: low 64 bits of address * GOLDEN from six 16x32 partial products
    logic [2:0]  hk_reg;
    logic [63:0] acc_reg;
    logic [15:0] ha;
    logic [31:0] hg;
    logic [47:0] prod;
    logic [63:0] term;

    always_comb
    begin
        ha   = address[15:0];
        hg   = GOLDEN[31:0];
        case (hk_reg)
            3'd0: begin ha = addr_reg[15:0];  hg = GOLDEN[31:0];  end
            3'd1: begin ha = addr_reg[31:16]; hg = GOLDEN[31:0];  end
            3'd2: begin ha = addr_reg[47:32]; hg = GOLDEN[31:0];  end
            3'd3: begin ha = addr_reg[63:48]; hg = GOLDEN[31:0];  end
            3'd4: begin ha = addr_reg[15:0];  hg = GOLDEN[63:32]; end
            3'd5: begin ha = addr_reg[31:16]; hg = GOLDEN[63:32]; end
            default: begin ha = '0; hg = '0; end
        endcase
        prod = 48'(ha) * 48'(hg);
        case (hk_reg)
            3'd0:       term = {16'd0, prod};
            3'd1:       term = {prod, 16'd0};
            3'd2, 3'd4: term = {prod[31:0], 32'd0};
            3'd3, 3'd5: term = {prod[15:0], 48'd0};
            default:    term = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.hash_clear)
        begin
            hk_reg  <= '0;
            acc_reg <= '0;
        end
        else if (ctrl.hash_step)
        begin
            hk_reg  <= hk_reg + 3'd1;
            acc_reg <= acc_reg + term;
        end
    end

    // probe and sweep pointers
    slot_t                probe_reg;
    logic [TABLE_BITS:0]  pcnt_reg;
    slot_t                sweep_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.probe_init)
        begin
            probe_reg <= acc_reg[63 -: TABLE_BITS];
            pcnt_reg  <= '0;
        end
        else if (ctrl.probe_next)
        begin
            probe_reg <= probe_reg + 1'b1;
            pcnt_reg  <= pcnt_reg + 1'b1;
        end
    end

    // start the clearing pass after reset from slot 0
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sweep_reg <= '0;
        else if (ctrl.sweep_clr)
            sweep_reg <= '0;
        else if (ctrl.sweep_inc)
            sweep_reg <= sweep_reg + 1'b1;
    end

    // pool counters
    logic [TABLE_BITS:0] used_reg;
    logic [14:0]         insns_reg;
    logic [15:0]         ops_reg;
    logic [16:0]         bytes_reg;
    logic                flushed_reg;
    entry_t              rd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg    <= '0;
            insns_reg   <= '0;
            ops_reg     <= '0;
            bytes_reg   <= '0;
            flushed_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.clr_counters)
            begin
                used_reg  <= '0;
                insns_reg <= '0;
                ops_reg   <= '0;
                bytes_reg <= '0;
            end
            else if (ctrl.commit_insert)
            begin
                if (rd.addr == '0)
                    used_reg <= used_reg + 1'b1;
                insns_reg <= insns_reg + 15'(ni_reg);
                ops_reg   <= ops_reg + 16'(no_reg);
                bytes_reg <= bytes_reg + 17'(nb_reg);
            end
            if (ctrl.load_req)
                flushed_reg <= 1'b0;
            else if (ctrl.set_flushed)
                flushed_reg <= 1'b1;
        end
    end

    // slot RAM
    slot_t  ram_addr;
    entry_t wr;
    logic   ram_we;

    always_comb
    begin
        case (ctrl.addr_sel)
            A_PROBE: ram_addr = probe_reg;
            A_DROP:  ram_addr = drop_reg;
            default: ram_addr = sweep_reg;
        endcase
        wr = rd;
        case (ctrl.wr_sel)
            WR_ZERO: wr = '0;
            WR_TOMB: wr.addr = TOMB;
            WR_ENTRY:
            begin
                wr.addr        = addr_reg;
                wr.mode        = mode_reg;
                wr.length      = nb_reg;
                wr.first_insn  = insns_reg[13:0];
                wr.insn_count  = ni_reg;
                wr.byte_offset = bytes_reg;
            end
            default: wr = rd;
        endcase
    end

    assign ram_we = (ctrl.wr_sel != WR_NONE);

    dbtt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TSIZE)
    ) u_ram (
        .clk   (clk),
        .addr  (ram_addr),
        .we    (ram_we),
        .wdata (wr),
        .rdata (rd)
    );

    // status
    logic [64:0] end_addr;
    assign end_addr = {1'b0, rd.addr} + 65'(rd.length);

    always_comb
    begin
        stat.cmd           = cmd_reg;
        stat.reserved_addr = (addr_reg == '0) || (addr_reg == TOMB);
        stat.hash_done     = (hk_reg == 3'(HASH_TERMS - 1));
        stat.need_flush    = (32'(used_reg) >= 32'(FULL_SLOTS))
                          || (32'(insns_reg) + 32'(MAX_BLOCK_INSNS) > 32'(INSN_POOL))
                          || (32'(ops_reg) + 32'(MAX_BLOCK_INSNS * MAX_INSN_OPERANDS)
                              > 32'(OPERAND_POOL))
                          || (32'(bytes_reg) + 32'(MAX_BLOCK_INSNS * MAX_INSN_BYTES)
                              > 32'(BYTE_POOL));
        stat.sweep_last    = (sweep_reg == slot_t'(TSIZE - 1));
        stat.probe_last    = (pcnt_reg == (TABLE_BITS + 1)'(TSIZE - 1));
        stat.entry_empty   = (rd.addr == '0);
        stat.entry_match   = (rd.addr == addr_reg) && (rd.mode == mode_reg);
        stat.entry_claim   = (rd.addr == '0) || (rd.addr == addr_reg);
        stat.inval_hit     = (rd.addr != '0) && (rd.addr != TOMB)
                          && (rd.addr < lim_reg) && (end_addr > {1'b0, addr_reg});
        stat.out_free      = !out_valid || !out_stall;
    end

    // pending result, then output register
    logic        r_hit_reg, r_fl_reg;
    logic [11:0] r_slot_reg;
    logic [13:0] r_fi_reg;
    logic [15:0] r_fo_reg;
    logic [16:0] r_bo_reg;
    logic [6:0]  r_ni_reg;
    logic [9:0]  r_nb_reg;

    always_ff @(posedge clk)
    begin
        case (ctrl.res_sel)
            RES_ZERO, RES_FLUSH:
            begin
                r_hit_reg  <= 1'b0;
                r_slot_reg <= '0;
                r_fi_reg   <= '0;
                r_fo_reg   <= '0;
                r_bo_reg   <= '0;
                r_ni_reg   <= '0;
                r_nb_reg   <= '0;
                r_fl_reg   <= (ctrl.res_sel == RES_FLUSH);
            end
            RES_HIT:
            begin
                r_hit_reg  <= 1'b1;
                r_slot_reg <= 12'(probe_reg);
                r_fi_reg   <= rd.first_insn;
                r_fo_reg   <= '0;
                r_bo_reg   <= rd.byte_offset;
                r_ni_reg   <= rd.insn_count;
                r_nb_reg   <= rd.length;
                r_fl_reg   <= 1'b0;
            end
            RES_INS:
            begin
                r_hit_reg  <= 1'b0;
                r_slot_reg <= 12'(probe_reg);
                r_fi_reg   <= insns_reg[13:0];
                r_fo_reg   <= ops_reg;
                r_bo_reg   <= bytes_reg;
                r_ni_reg   <= ni_reg;
                r_nb_reg   <= nb_reg;
                r_fl_reg   <= flushed_reg;
            end
            default:
            begin
                r_hit_reg <= r_hit_reg;
            end
        endcase
        if (ctrl.out_set)
        begin
            hit           <= r_hit_reg;
            slot          <= r_slot_reg;
            first_insn    <= r_fi_reg;
            first_operand <= r_fo_reg;
            byte_offset   <= r_bo_reg;
            block_insns   <= r_ni_reg;
            block_bytes   <= r_nb_reg;
            flushed       <= r_fl_reg;
        end
    end

    logic out_valid_reg;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ctrl.out_set)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

endmodule

/* rtl/core/dbtt_checker.sv */
// ----------------------------------------------------------------------------
// dbtt_checker
// Port-level checks of the decoded block tag table.
// ----------------------------------------------------------------------------
module dbtt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic        hit,
    input logic [15:0] first_operand,
    input logic [6:0]  block_insns,
    input logic [9:0]  block_bytes,
    input logic        flushed
);
    import dbtt_pkg::*;

    // a waiting result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(hit) && $stable(block_insns))
        else $error("stalled result changed");

    a_hit_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit |-> first_operand == '0 && !flushed)
        else $error("lookup hit carries insert-only fields");

    a_hit_sizes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit |-> block_insns <= 7'(MAX_BLOCK_INSNS)
            && 11'(block_bytes) <= 11'(block_insns) * 11'(MAX_INSN_BYTES))
        else $error("hit reports block beyond size limits");

    a_flush_miss: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && flushed |-> !hit)
        else $error("flush reported together with a hit");

endmodule

bind decoded_block_tag_table dbtt_checker u_dbtt_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .hit           (hit),
    .first_operand (first_operand),
    .block_insns   (block_insns),
    .block_bytes   (block_bytes),
    .flushed       (flushed)
);

/* tb/tb_decoded_block_tag_table.sv */
// ----------------------------------------------------------------------------
// tb_decoded_block_tag_table
// Self-checking regression of the decoded block tag table: a cycle-free
// predictor of the hash table tracks every accepted request, and each result
// is compared field by field with the oldest predicted one. Both handshake
// sides idle at random; named tests cover lookup, insert, invalidate, flush,
// drop, the reserved addresses and saturation.
// ----------------------------------------------------------------------------
module tb_decoded_block_tag_table;

    import dbtt_pkg::*;

    localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
    localparam logic [2:0] CMD_UNUSED_HI = 3'd7;
    localparam int POOL_SIZE   = 40;
    localparam int QUIET_LIMIT = 40000;
    localparam int TAIL_CYCLES = 64;

    typedef struct packed {
        logic        hit;
        logic [11:0] slot;
        logic [13:0] first_insn;
        logic [15:0] first_operand;
        logic [16:0] byte_offset;
        logic [6:0]  block_insns;
        logic [9:0]  block_bytes;
        logic        flushed;
    } tag_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [2:0]  command = '0;
    logic [63:0] address = '0;
    logic [63:0] limit_address = '0;
    logic [7:0]  cpu_mode = '0;
    logic [9:0]  block_length = '0;
    logic [6:0]  insn_count = '0;
    logic [9:0]  operand_total = '0;
    logic [11:0] slot_index = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        hit;
    logic [11:0] slot;
    logic [13:0] first_insn;
    logic [15:0] first_operand;
    logic [16:0] byte_offset;
    logic [6:0]  block_insns;
    logic [9:0]  block_bytes;
    logic        flushed;

    decoded_block_tag_table dut (.*);

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // predicted table contents
    logic [63:0] tag_addr   [TSIZE];
    logic [7:0]  tag_mode   [TSIZE];
    logic [9:0]  tag_len    [TSIZE];
    logic [13:0] tag_insn   [TSIZE];
    logic [6:0]  tag_count  [TSIZE];
    logic [16:0] tag_boff   [TSIZE];
    int          slots_taken;
    int          insns_taken;
    int          operands_taken;
    int          bytes_taken;

    tag_result_t expected_results[$];
    logic [63:0] known_addr[POOL_SIZE];
    int          errors = 0;
    bit          sender_idles = 1'b1;
    bit          receiver_idles = 1'b1;
    int          quiet_cycles = 0;
    int          hold_left = 0;

    function automatic logic [11:0] home_of(logic [63:0] a);
        logic [63:0] h;
        h = a * GOLDEN;
        return h[63:64-TABLE_BITS];
    endfunction

    function automatic void wipe_table();
        for (int i = 0; i < TSIZE; i++)
        begin
            tag_addr[i]  = '0;
            tag_mode[i]  = '0;
            tag_len[i]   = '0;
            tag_insn[i]  = '0;
            tag_count[i] = '0;
            tag_boff[i]  = '0;
        end
        slots_taken    = 0;
        insns_taken    = 0;
        operands_taken = 0;
        bytes_taken    = 0;
    endfunction

    function automatic tag_result_t predict_table(logic [2:0] cmd, logic [63:0] a,
            logic [63:0] lim, logic [7:0] mode, logic [9:0] len, logic [6:0] cnt,
            logic [9:0] ops, logic [11:0] sl);
        tag_result_t r;
        int          ni, no, nb, n;
        logic [11:0] h;
        r = '0;
        case (cmd)
            CMD_LOOKUP:
            begin
                if (a != '0 && a != TOMB)
                begin
                    h = home_of(a);
                    for (n = 0; n < TSIZE; n++)
                    begin
                        if (tag_addr[h] == '0)
                            break;
                        if (tag_addr[h] == a && tag_mode[h] == mode)
                        begin
                            r.hit         = 1'b1;
                            r.slot        = h;
                            r.first_insn  = tag_insn[h];
                            r.byte_offset = tag_boff[h];
                            r.block_insns = tag_count[h];
                            r.block_bytes = tag_len[h];
                            break;
                        end
                        h = h + 1'b1;
                    end
                end
            end
            CMD_INSERT:
            begin
                if (a != '0 && a != TOMB)
                begin
                    if (slots_taken >= FULL_SLOTS
                        || insns_taken + MAX_BLOCK_INSNS > INSN_POOL
                        || operands_taken + MAX_BLOCK_INSNS * MAX_INSN_OPERANDS
                           > OPERAND_POOL
                        || bytes_taken + MAX_BLOCK_INSNS * MAX_INSN_BYTES > BYTE_POOL)
                    begin
                        wipe_table();
                        r.flushed = 1'b1;
                    end
                    ni = (cnt > MAX_BLOCK_INSNS) ? MAX_BLOCK_INSNS : cnt;
                    no = (ops > ni * MAX_INSN_OPERANDS) ? ni * MAX_INSN_OPERANDS : ops;
                    nb = (len > ni * MAX_INSN_BYTES) ? ni * MAX_INSN_BYTES : len;
                    h = home_of(a);
                    for (n = 0; n < TSIZE; n++)
                    begin
                        if (tag_addr[h] == '0 || tag_addr[h] == a)
                            break;
                        h = h + 1'b1;
                    end
                    if (tag_addr[h] == '0)
                        slots_taken++;
                    tag_addr[h]  = a;
                    tag_mode[h]  = mode;
                    tag_len[h]   = 10'(nb);
                    tag_insn[h]  = 14'(insns_taken);
                    tag_count[h] = 7'(ni);
                    tag_boff[h]  = 17'(bytes_taken);
                    r.slot          = h;
                    r.first_insn    = 14'(insns_taken);
                    r.first_operand = 16'(operands_taken);
                    r.byte_offset   = 17'(bytes_taken);
                    r.block_insns   = 7'(ni);
                    r.block_bytes   = 10'(nb);
                    insns_taken    += ni;
                    operands_taken += no;
                    bytes_taken    += nb;
                end
            end
            CMD_INVAL:
            begin
                for (int i = 0; i < TSIZE; i++)
                begin
                    // end of block taken without wrap
                    if (tag_addr[i] != '0 && tag_addr[i] != TOMB && tag_addr[i] < lim
                        && ({1'b0, tag_addr[i]} + tag_len[i]) > {1'b0, a})
                        tag_addr[i] = TOMB;
                end
            end
            CMD_FLUSH:
            begin
                wipe_table();
                r.flushed = 1'b1;
            end
            CMD_DROP:
            begin
                if (tag_addr[sl] != '0)
                    tag_addr[sl] = TOMB;
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    task automatic send_request(logic [2:0] cmd, logic [63:0] a, logic [63:0] lim,
            logic [7:0] mode, logic [9:0] len, logic [6:0] cnt, logic [9:0] ops,
            logic [11:0] sl);
        int gap;
        gap = sender_idles ? $urandom_range(0, 7) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        command       <= cmd;
        address       <= a;
        limit_address <= lim;
        cpu_mode      <= mode;
        block_length  <= len;
        insn_count    <= cnt;
        operand_total <= ops;
        slot_index    <= sl;
        do
            @(posedge clk);
        while (in_stall);
        expected_results.push_back(predict_table(cmd, a, lim, mode, len, cnt, ops, sl));
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [63:0] pick_addr();
        return known_addr[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    task automatic insert_random(logic [63:0] a);
        send_request(CMD_INSERT, a, {$urandom, $urandom}, $urandom_range(0, 3),
            $urandom_range(1, 960), $urandom_range(1, 64), $urandom_range(0, 640),
            $urandom);
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: result with none expected, actual hit=%0d slot=%0d",
                    $time, hit, slot);
                errors++;
            end
            else
            begin : compare
                tag_result_t e;
                tag_result_t got;
                e = expected_results.pop_front();
                got = {hit, slot, first_insn, first_operand, byte_offset,
                       block_insns, block_bytes, flushed};
                if (got.hit != e.hit)
                    $display("%0t: hit expected %0d actual %0d", $time, e.hit, got.hit);
                if (got.slot != e.slot)
                    $display("%0t: slot expected %0d actual %0d", $time, e.slot, got.slot);
                if (got.first_insn != e.first_insn)
                    $display("%0t: first_insn expected %0d actual %0d", $time,
                        e.first_insn, got.first_insn);
                if (got.first_operand != e.first_operand)
                    $display("%0t: first_operand expected %0d actual %0d", $time,
                        e.first_operand, got.first_operand);
                if (got.byte_offset != e.byte_offset)
                    $display("%0t: byte_offset expected %0d actual %0d", $time,
                        e.byte_offset, got.byte_offset);
                if (got.block_insns != e.block_insns)
                    $display("%0t: block_insns expected %0d actual %0d", $time,
                        e.block_insns, got.block_insns);
                if (got.block_bytes != e.block_bytes)
                    $display("%0t: block_bytes expected %0d actual %0d", $time,
                        e.block_bytes, got.block_bytes);
                if (got.flushed != e.flushed)
                    $display("%0t: flushed expected %0d actual %0d", $time,
                        e.flushed, got.flushed);
                if (got != e)
                    errors++;
            end
        end
    end

    // result side stall: hold for a freshly drawn number of cycles after every result
    always @(posedge clk)
    begin : result_side
        int hold;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                hold = receiver_idles ? $urandom_range(0, 7) : 0;
                hold_left <= hold;
                out_stall <= (hold > 0);
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                out_stall <= (hold_left > 1);
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("decoded_block_tag_table regression: fail");
            $finish;
        end
    end

    task automatic test_directed();
        logic [63:0] a;
        a = known_addr[0];
        send_request(CMD_LOOKUP, a, '0, 8'd0, '0, '0, '0, '0);
        send_request(CMD_INSERT, a, '0, 8'hFF, 10'd1023, 7'd127, 10'd1023, 12'hFFF);
        send_request(CMD_LOOKUP, a, '0, 8'hFF, '0, '0, '0, '0);
        send_request(CMD_LOOKUP, a, '0, 8'h00, '0, '0, '0, '0);
        // same address again: overwrite with new mode
        send_request(CMD_INSERT, a, '0, 8'h00, 10'd960, 7'd64, 10'd640, '0);
        send_request(CMD_LOOKUP, a, '0, 8'h00, '0, '0, '0, '0);
        send_request(CMD_INSERT, known_addr[1], '0, 8'h5A, 10'd900, 7'd2, 10'd700, '0);
        send_request(CMD_INSERT, known_addr[2], '0, 8'h01, 10'd5, 7'd0, 10'd3, '0);
        send_request(CMD_LOOKUP, known_addr[2], '0, 8'h01, '0, '0, '0, '0);
        // reserved addresses
        send_request(CMD_INSERT, '0, '0, 8'h01, 10'd5, 7'd1, 10'd1, '0);
        send_request(CMD_INSERT, TOMB, TOMB, 8'h01, 10'd5, 7'd1, 10'd1, '0);
        send_request(CMD_LOOKUP, '0, '0, 8'h00, '0, '0, '0, '0);
        send_request(CMD_LOOKUP, TOMB, '0, 8'h00, '0, '0, '0, '0);
        // colliding addresses share a probe chain
        send_request(CMD_INSERT, known_addr[3], '0, 8'h00, 10'd10, 7'd3, 10'd4, '0);
        send_request(CMD_INSERT, known_addr[4], '0, 8'h00, 10'd10, 7'd3, 10'd4, '0);
        send_request(CMD_DROP, '0, '0, '0, '0, '0, '0, home_of(known_addr[3]));
        send_request(CMD_LOOKUP, known_addr[4], '0, 8'h00, '0, '0, '0, '0);
        send_request(CMD_DROP, '0, '0, '0, '0, '0, '0, 12'hFFF);
        send_request(CMD_UNUSED_LO, a, TOMB, 8'hFF, 10'd1023, 7'd127, 10'd1023, 12'hFFF);
        send_request(CMD_UNUSED_HI, a, '0, '0, '0, '0, '0, '0);
        send_request(CMD_INVAL, a, a + 1, '0, '0, '0, '0, '0);
        send_request(CMD_LOOKUP, a, '0, 8'h00, '0, '0, '0, '0);
        send_request(CMD_INVAL, '0, TOMB, '0, '0, '0, '0, '0);
        send_request(CMD_FLUSH, '0, '0, '0, '0, '0, '0, '0);
    endtask

    task automatic test_wrapping_block();
        logic [63:0] top;
        top = 64'hFFFF_FFFF_FFFF_FF80;
        send_request(CMD_INSERT, top, '0, 8'h07, 10'd900, 7'd64, 10'd0, '0);
        send_request(CMD_INVAL, 64'hFFFF_FFFF_FFFF_FFF0, TOMB, '0, '0, '0, '0, '0);
        send_request(CMD_LOOKUP, top, '0, 8'h07, '0, '0, '0, '0);
    endtask

    task automatic test_random(int count);
        int          sel;
        logic [63:0] a;
        for (int i = 0; i < count; i++)
        begin
            if (i % 200 == 0)
                sender_idles = $urandom_range(0, 3) != 0;
            if (i % 150 == 0)
                receiver_idles = $urandom_range(0, 3) != 0;
            sel = $urandom_range(0, 999);
            a = pick_addr();
            if (sel < 400)
                send_request(CMD_LOOKUP, a, {$urandom, $urandom}, $urandom_range(0, 3),
                    $urandom, $urandom, $urandom, $urandom);
            else if (sel < 800)
                insert_random(a);
            else if (sel < 815)
                send_request(CMD_INVAL, a - $urandom_range(0, 1000),
                    a + $urandom_range(0, 1000), $urandom, $urandom, $urandom, $urandom,
                    $urandom);
            else if (sel < 825)
                send_request(CMD_FLUSH, {$urandom, $urandom}, {$urandom, $urandom},
                    $urandom, $urandom, $urandom, $urandom, $urandom);
            else if (sel < 905)
                send_request(CMD_DROP, a, '0, $urandom, $urandom, $urandom, $urandom,
                    ($urandom_range(0, 3) == 0) ? 12'($urandom) : home_of(a));
            else if (sel < 925)
                send_request(3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI)),
                    {$urandom, $urandom}, {$urandom, $urandom}, $urandom, $urandom,
                    $urandom, $urandom, $urandom);
            else if (sel < 960)
                send_request(CMD_LOOKUP, {$urandom, $urandom}, '0, $urandom, '0, '0, '0,
                    '0);
            else
                // full-width fields to reach saturation
                send_request(CMD_INSERT, a, {$urandom, $urandom}, $urandom, $urandom,
                    $urandom, $urandom, $urandom);
            if (i == count / 2)
                wait_drained();
        end
    endtask

    initial
    begin
        wipe_table();
        for (int i = 0; i < POOL_SIZE; i++)
            known_addr[i] = {$urandom, $urandom} | 64'h2;
        // force a chain of addresses onto one home slot
        for (int i = 3; i < 6; i++)
            do
                known_addr[i] = {$urandom, $urandom} | 64'h2;
            while (home_of(known_addr[i]) != home_of(known_addr[0]));
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_wrapping_block();
        wait_drained();
        test_random(1400);
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("decoded_block_tag_table regression: pass");
        else
            $display("decoded_block_tag_table regression: fail");
        $finish;
    end

endmodule
